// ===== hdl/ehcd_pkg.sv =====
// ehcd_pkg: request and result types, presence mask bit positions and
// default sizes for the event header context decoder
// depends on nothing
package ehcd_pkg;

  localparam int unsigned LEVEL_COUNT_DEF = 4;
  localparam int unsigned MASK_W          = 11;
  localparam int unsigned PUB_W           = 6;
  localparam int unsigned IMP_W           = 3;
  localparam int unsigned WORD_W          = 64;

  // presence mask bit positions
  localparam int unsigned M_SOURCE     = 0;
  localparam int unsigned M_IMPORTANCE = 1;
  localparam int unsigned M_ID         = 2;
  localparam int unsigned M_TYPE       = 3;
  localparam int unsigned M_INSTANCE   = 4;
  localparam int unsigned M_SYS        = 5;
  localparam int unsigned M_UTC        = 6;
  localparam int unsigned M_DSYS       = 7;
  localparam int unsigned M_DUTC       = 8;
  localparam int unsigned M_RELIMP     = 9;
  localparam int unsigned M_RELID      = 10;

  localparam logic [IMP_W-1:0] FIRST_LEVEL = IMP_W'(1);

  typedef struct packed {
    logic                     first_of_list;
    logic [WORD_W-1:0]        publisher_source;
    logic [MASK_W-1:0]        present_mask;
    logic [WORD_W-1:0]        source_value;
    logic [IMP_W-1:0]         importance_value;
    logic [WORD_W-1:0]        event_number;
    logic [WORD_W-1:0]        type_value;
    logic [WORD_W-1:0]        instance_value;
    logic [WORD_W-1:0]        system_stamp;
    logic [WORD_W-1:0]        utc_stamp;
    logic signed [WORD_W-1:0] system_delta;
    logic signed [WORD_W-1:0] utc_delta;
  } ehcd_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_source;
    logic [IMP_W-1:0]  out_importance;
    logic [WORD_W-1:0] out_event_number;
    logic [WORD_W-1:0] out_type;
    logic [WORD_W-1:0] out_instance;
    logic [WORD_W-1:0] out_system_stamp;
    logic [WORD_W-1:0] out_utc_stamp;
    logic [PUB_W-1:0]  published_mask;
    logic              is_new;
    logic              gap_found;
  } ehcd_rsp_t;

  // qualified header handed from the fill stage to the tracker and result
  typedef struct packed {
    logic [WORD_W-1:0] source;
    logic [IMP_W-1:0]  importance;
    logic [WORD_W-1:0] event_number;
    logic [WORD_W-1:0] type_id;
    logic [WORD_W-1:0] instance_id;
    logic [WORD_W-1:0] system_stamp;
    logic [WORD_W-1:0] utc_stamp;
    logic [PUB_W-1:0]  published;
  } ehcd_fill_t;

endpackage

// ===== hdl/ehcd_fill.sv =====
// ehcd_fill: running list context and the fill-in of absent header fields
// depends on ehcd_pkg
module ehcd_fill (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  ehcd_pkg::ehcd_req_t  req,
  output ehcd_pkg::ehcd_fill_t fill
);
  import ehcd_pkg::*;

  logic [IMP_W-1:0]  ctx_imp_r,  ctx_imp_nxt;
  logic [WORD_W-1:0] ctx_id_r,   ctx_id_nxt;
  logic [WORD_W-1:0] ctx_type_r, ctx_type_nxt;
  logic [WORD_W-1:0] ctx_sys_r,  ctx_sys_nxt;
  logic [WORD_W-1:0] ctx_utc_r,  ctx_utc_nxt;

  logic [IMP_W-1:0]  base_imp;
  logic [WORD_W-1:0] base_id, base_type, base_sys, base_utc;
  logic [MASK_W-1:0] m;

  always_comb begin
    m = req.present_mask;
    // a new list starts from a cleared context, with importance at the first level
    if (req.first_of_list) begin
      base_imp  = FIRST_LEVEL;
      base_id   = '0;
      base_type = '0;
      base_sys  = '0;
      base_utc  = '0;
    end else begin
      base_imp  = ctx_imp_r;
      base_id   = ctx_id_r;
      base_type = ctx_type_r;
      base_sys  = ctx_sys_r;
      base_utc  = ctx_utc_r;
    end

    fill.source       = m[M_SOURCE] ? req.source_value : req.publisher_source;
    fill.importance   = m[M_IMPORTANCE] ? req.importance_value : base_imp;
    fill.event_number = m[M_ID] ? req.event_number : base_id + WORD_W'(1);
    fill.type_id      = m[M_TYPE] ? req.type_value : base_type;
    fill.instance_id  = m[M_INSTANCE] ? req.instance_value : '0;

    ctx_sys_nxt = base_sys;
    fill.system_stamp = '0;
    if (m[M_SYS]) begin
      fill.system_stamp = req.system_stamp;
      ctx_sys_nxt       = req.system_stamp;
    end else if (m[M_DSYS]) begin
      fill.system_stamp = base_sys + unsigned'(req.system_delta);
      ctx_sys_nxt       = fill.system_stamp;
    end

    ctx_utc_nxt = base_utc;
    fill.utc_stamp = '0;
    if (m[M_UTC]) begin
      fill.utc_stamp = req.utc_stamp;
      ctx_utc_nxt    = req.utc_stamp;
    end else if (m[M_DUTC]) begin
      fill.utc_stamp = base_utc + unsigned'(req.utc_delta);
      ctx_utc_nxt    = fill.utc_stamp;
    end

    fill.published = {m[M_DSYS], m[M_DUTC], m[M_SYS], m[M_UTC], m[M_RELID], m[M_RELIMP]};

    ctx_imp_nxt  = fill.importance;
    ctx_id_nxt   = fill.event_number;
    ctx_type_nxt = fill.type_id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_imp_r  <= FIRST_LEVEL;
      ctx_id_r   <= '0;
      ctx_type_r <= '0;
      ctx_sys_r  <= '0;
      ctx_utc_r  <= '0;
    end else if (en) begin
      ctx_imp_r  <= ctx_imp_nxt;
      ctx_id_r   <= ctx_id_nxt;
      ctx_type_r <= ctx_type_nxt;
      ctx_sys_r  <= ctx_sys_nxt;
      ctx_utc_r  <= ctx_utc_nxt;
    end
  end

endmodule

// ===== hdl/ehcd_track.sv =====
// ehcd_track: largest event id seen per importance level, new and gap flags
// depends on ehcd_pkg
module ehcd_track #(
  parameter int unsigned LEVEL_COUNT = ehcd_pkg::LEVEL_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [ehcd_pkg::IMP_W-1:0]  importance,
  input  logic [ehcd_pkg::WORD_W-1:0] event_number,
  output logic                        is_new,
  output logic                        gap_found
);
  import ehcd_pkg::*;

  localparam int unsigned IDX_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

  logic [WORD_W-1:0] largest_r [LEVEL_COUNT];
  logic [IMP_W-1:0]  imp_m1;
  logic [IDX_W-1:0]  idx;
  logic              in_range;
  logic [WORD_W-1:0] big;
  logic              upd;

  always_comb begin
    imp_m1   = importance - IMP_W'(1);
    idx      = IDX_W'(imp_m1);
    in_range = (importance != '0) && (32'(importance) <= LEVEL_COUNT);
    big      = in_range ? largest_r[idx] : '0;
    is_new    = 1'b0;
    gap_found = 1'b0;
    // zero reads as nothing seen yet for that level
    if (in_range) begin
      if (big == '0) begin
        is_new = 1'b1;
      end else if (event_number > big) begin
        is_new    = 1'b1;
        gap_found = (event_number != big + WORD_W'(1));
      end
    end
    upd = en && is_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVEL_COUNT; i++) largest_r[i] <= '0;
    end else if (upd) begin
      largest_r[idx] <= event_number;
    end
  end

endmodule

// ===== hdl/event_header_context_decoder.sv =====
// event_header_context_decoder: top level, input request register, fill
// stage, per-level tracker and result register; depends on ehcd_pkg,
// ehcd_fill and ehcd_track
//
//   channel  ports                            moves
//   input    in_valid  in_stall  in_data      one compressed header request
//   result   out_valid out_stall out_data     one qualified header
//
// one request per cycle sustained while the result is not stalled; a request
// moves from the input register through fill and tracking logic into the result register
// the context and largest-id table advance as a request moves to the result
// reset clears the context, the largest-id table and both valid flags
// a stalled result holds the pipe; one more request may wait in the input
// register before in_stall rises
module event_header_context_decoder #(
  parameter int unsigned LEVEL_COUNT = ehcd_pkg::LEVEL_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ehcd_pkg::ehcd_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ehcd_pkg::ehcd_rsp_t out_data
);
  import ehcd_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  ehcd_req_t  s1_req_r;
  logic       out_valid_r, out_valid_nxt;
  ehcd_rsp_t  out_data_r;
  ehcd_fill_t fill;
  logic       advance;
  logic       load_s1;
  logic       is_new, gap_found;

  assign advance  = !(out_valid_r && out_stall);
  // an empty input register takes a request even while the result waits
  assign load_s1  = advance || !s1_valid_r;
  assign in_stall = !load_s1;

  ehcd_fill u_fill (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (advance && s1_valid_r),
    .req  (s1_req_r),
    .fill (fill)
  );

  ehcd_track #(.LEVEL_COUNT(LEVEL_COUNT)) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance && s1_valid_r),
    .importance  (fill.importance),
    .event_number(fill.event_number),
    .is_new      (is_new),
    .gap_found   (gap_found)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
    if (load_s1) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_req_r <= in_data;
    end
    if (advance) begin
      if (s1_valid_r) begin
        out_data_r.out_source       <= fill.source;
        out_data_r.out_importance   <= fill.importance;
        out_data_r.out_event_number <= fill.event_number;
        out_data_r.out_type         <= fill.type_id;
        out_data_r.out_instance     <= fill.instance_id;
        out_data_r.out_system_stamp <= fill.system_stamp;
        out_data_r.out_utc_stamp    <= fill.utc_stamp;
        out_data_r.published_mask   <= fill.published;
        out_data_r.is_new           <= is_new;
        out_data_r.gap_found        <= gap_found;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
